/* rtl/farc_pkg.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// farc_pkg
// Shared constants and helpers for the fully associative tag cache with
// pseudo-random replacement.
// ----------------------------------------------------------------------------
package farc_pkg;

  // Default geometry
  localparam int WAYS_DEF     = 16;
  localparam int TAG_BITS_DEF = 32;

  // Port field widths
  localparam int TAG_W   = 32;
  localparam int WAY_W   = 4;
  localparam int COUNT_W = 32;
  localparam int CFG_W   = 5;

  // Victim LFSR
  localparam int           LFSR_W    = 16;
  localparam logic [15:0]  LFSR_SEED = 16'hACE1;
  localparam logic [15:0]  LFSR_TAPS = 16'hB400;

  localparam logic [CFG_W-1:0]   WAYS_IN_USE_RST = 5'd16;
  localparam logic [COUNT_W-1:0] COUNT_MAX       = '1;

  // One Galois step: shift right, fold taps in when the lsb falls out.
  function automatic logic [LFSR_W-1:0] lfsr_step(input logic [LFSR_W-1:0] v);
    logic [LFSR_W-1:0] r;
    r = v >> 1;
    if (v[0]) begin
      r = r ^ LFSR_TAPS;
    end
    return r;
  endfunction

  function automatic logic [COUNT_W-1:0] sat_inc(input logic [COUNT_W-1:0] v);
    return (v == COUNT_MAX) ? v : v + COUNT_W'(1);
  endfunction

endpackage

/* rtl/farc_tag_match.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// farc_tag_match
// Parallel tag compare against all filled slots, lowest matching slot wins.
// ----------------------------------------------------------------------------
module farc_tag_match #(
  parameter int WAYS  = 16,
  parameter int KEY_W = 32,
  parameter int IDX_W = 4,
  parameter int CNT_W = 5
) (
  input  logic [KEY_W-1:0] tag_i,
  input  logic [KEY_W-1:0] store_i [WAYS],
  input  logic [CNT_W-1:0] filled_i,
  output logic             hit_o,
  output logic [IDX_W-1:0] slot_o
);

  logic [WAYS-1:0] match;

  always_comb begin
    for (int i = 0; i < WAYS; i++) begin
      match[i] = (CNT_W'(i) < filled_i) && (store_i[i] == tag_i);
    end
  end

  // descending scan so the lowest match is the one left standing
  always_comb begin
    hit_o  = |match;
    slot_o = '0;
    for (int i = WAYS - 1; i >= 0; i--) begin
      if (match[i]) begin
        slot_o = IDX_W'(i);
      end
    end
  end

endmodule

/* rtl/fully_assoc_cache_random_repl.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// fully_assoc_cache_random_repl
// Fully associative cache of block tags with LFSR-driven random replacement.
// ----------------------------------------------------------------------------
// Path: the tag waits in the input register while the lookup/update logic loads
//   the result register; a stalled result holds it in the input register.
// Throughput: one transaction per cycle unless the result stalls; the single
//   lookup pass sets the rate, state updates land before the next lookup.
// Reset: fill count, counters, valids cleared, LFSR to 0xACE1, ways_in_use
//   to 16. Tag storage is not reset; slots beyond the fill count never match.
// ----------------------------------------------------------------------------
module fully_assoc_cache_random_repl
  #(
  parameter int WAYS     = farc_pkg::WAYS_DEF,
  parameter int TAG_BITS = farc_pkg::TAG_BITS_DEF
) (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  // config
  input  logic                         cfg_we_i,
  input  logic [farc_pkg::CFG_W-1:0]   cfg_wdata_i,
  // request channel
  input  logic                         in_valid_i,
  output logic                         in_ready_o,
  input  logic [farc_pkg::TAG_W-1:0]   tag_i,
  // result channel
  output logic                         out_valid_o,
  input  logic                         out_ready_i,
  output logic                         hit_o,
  output logic [farc_pkg::WAY_W-1:0]   way_o,
  output logic [farc_pkg::COUNT_W-1:0] hit_count_o,
  output logic [farc_pkg::COUNT_W-1:0] access_count_o
);

  import farc_pkg::*;

  // Only the low TAG_BITS of the tag take part; above 32 the rest is zero,
  // so the stored key never needs more than the port width.
  localparam int KEY_W = (TAG_BITS < TAG_W) ? TAG_BITS : TAG_W;
  localparam int IDX_W = (WAYS > 1) ? $clog2(WAYS) : 1;
  localparam int CNT_W = $clog2(WAYS + 1);
  localparam int EXT_W = 8;
  localparam logic [EXT_W-1:0] WAYS_EXT = EXT_W'(WAYS);

  // --------------------------------------------------------------------------
  // State
  // --------------------------------------------------------------------------
  logic [CFG_W-1:0]   ways_cfg_q;
  logic [KEY_W-1:0]   tag_store_q [WAYS];
  logic [CNT_W-1:0]   filled_q, filled_d;
  logic [LFSR_W-1:0]  lfsr_q, lfsr_d;
  logic [COUNT_W-1:0] hits_q, hits_d;
  logic [COUNT_W-1:0] accs_q, accs_d;

  // input stage
  logic               req_vld_q;
  logic [KEY_W-1:0]   req_tag_q;

  // result stage
  logic               res_vld_q;
  logic               res_hit_q, res_hit_d;
  logic [WAY_W-1:0]   res_way_q, res_way_d;

  // The lookup fires when a request is staged and the result slot is free
  // or being drained this cycle.
  logic advance;
  assign advance    = req_vld_q && (!res_vld_q || out_ready_i);
  assign in_ready_o = !req_vld_q || advance;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ways_cfg_q <= WAYS_IN_USE_RST;
    end else if (cfg_we_i) begin
      ways_cfg_q <= cfg_wdata_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      req_vld_q <= 1'b0;
    end else if (in_ready_o) begin
      req_vld_q <= in_valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_ready_o && in_valid_i) begin
      req_tag_q <= tag_i[KEY_W-1:0];
    end
  end

  // --------------------------------------------------------------------------
  // Effective way count: 0 acts as 1, anything above WAYS clamps to WAYS
  // --------------------------------------------------------------------------
  logic [EXT_W-1:0] ways_ext;
  logic [CNT_W-1:0] ways_eff;

  always_comb begin
    ways_ext = EXT_W'(ways_cfg_q);
    if (ways_ext == '0) begin
      ways_ext = EXT_W'(1);
    end else if (ways_ext > WAYS_EXT) begin
      ways_ext = WAYS_EXT;
    end
    ways_eff = ways_ext[CNT_W-1:0];
  end

  // --------------------------------------------------------------------------
  // Tag compare
  // --------------------------------------------------------------------------
  logic             lookup_hit;
  logic [IDX_W-1:0] lookup_slot;

  farc_tag_match #(
    .WAYS  (WAYS),
    .KEY_W (KEY_W),
    .IDX_W (IDX_W),
    .CNT_W (CNT_W)
  ) u_match (
    .tag_i    (req_tag_q),
    .store_i  (tag_store_q),
    .filled_i (filled_q),
    .hit_o    (lookup_hit),
    .slot_o   (lookup_slot)
  );

  // --------------------------------------------------------------------------
  // Victim pick: step LFSR, scale into 0..ways-1 via (lfsr * ways) >> 16
  // --------------------------------------------------------------------------
  logic [LFSR_W-1:0]       lfsr_next;
  logic [LFSR_W+CNT_W-1:0] victim_prod;
  logic [CNT_W-1:0]        victim_raw;
  logic [IDX_W-1:0]        victim_slot;

  always_comb begin
    lfsr_next   = lfsr_step(lfsr_q);
    victim_prod = (LFSR_W+CNT_W)'(lfsr_next) * (LFSR_W+CNT_W)'(ways_eff);
    victim_raw  = victim_prod[LFSR_W+CNT_W-1:LFSR_W];
    if (victim_raw >= ways_eff) begin
      victim_raw = ways_eff - CNT_W'(1);
    end
    victim_slot = victim_raw[IDX_W-1:0];
  end

  // --------------------------------------------------------------------------
  // Update: hit / append / replace
  // --------------------------------------------------------------------------
  logic             wr_en;
  logic [IDX_W-1:0] wr_slot;
  logic [IDX_W-1:0] slot_sel;
  logic [EXT_W-1:0] slot_ext;

  always_comb begin
    filled_d = filled_q;
    lfsr_d   = lfsr_q;
    hits_d   = hits_q;
    accs_d   = sat_inc(accs_q);
    wr_en    = 1'b0;
    wr_slot  = filled_q[IDX_W-1:0];
    slot_sel = lookup_slot;

    if (lookup_hit) begin
      hits_d = sat_inc(hits_q);
    end else if (filled_q < ways_eff) begin
      // free slot left: append
      wr_en    = 1'b1;
      wr_slot  = filled_q[IDX_W-1:0];
      slot_sel = filled_q[IDX_W-1:0];
      filled_d = filled_q + CNT_W'(1);
    end else begin
      wr_en    = 1'b1;
      wr_slot  = victim_slot;
      slot_sel = victim_slot;
      lfsr_d   = lfsr_next;
    end

    slot_ext  = EXT_W'(slot_sel);
    res_hit_d = lookup_hit;
    res_way_d = slot_ext[WAY_W-1:0];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      filled_q <= '0;
      lfsr_q   <= LFSR_SEED;
      hits_q   <= '0;
      accs_q   <= '0;
    end else if (advance) begin
      filled_q <= filled_d;
      lfsr_q   <= lfsr_d;
      hits_q   <= hits_d;
      accs_q   <= accs_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (advance && wr_en) begin
      tag_store_q[wr_slot] <= req_tag_q;
    end
  end

  // --------------------------------------------------------------------------
  // Result register. Counters are read straight from state: they only move
  // on an advance, which is also the only time the result reloads.
  // --------------------------------------------------------------------------
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      res_vld_q <= 1'b0;
    end else if (advance) begin
      res_vld_q <= 1'b1;
    end else if (out_ready_i) begin
      res_vld_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (advance) begin
      res_hit_q <= res_hit_d;
      res_way_q <= res_way_d;
    end
  end

  assign out_valid_o    = res_vld_q;
  assign hit_o          = res_hit_q;
  assign way_o          = res_way_q;
  assign hit_count_o    = hits_q;
  assign access_count_o = accs_q;

endmodule

/* tb/sv/tb_fully_assoc_cache_random_repl.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_fully_assoc_cache_random_repl
// Self-checking bench for the fully associative tag cache. Tag transactions
// go in through a valid/ready driver with random gaps. Results come back
// through a monitor with random ready stalls. Each result is checked against
// a local model of the tag store, fill count, victim LFSR and the saturating
// counters. The way count changes between phases, including out-of-range
// values, and the stimulus is a working set of tags that gives both hits and
// replacements.
// ----------------------------------------------------------------------------
module tb_fully_assoc_cache_random_repl;

  import farc_pkg::*;

  localparam int NUM_WAYS      = WAYS_DEF;
  localparam int CLK_HALF_NS   = 4;
  localparam int RAND_PHASES   = 8;
  localparam int PHASE_ITEMS   = 128;
  localparam int POOL_SIZE     = 20;
  localparam int DRAIN_CYCLES  = 4;     // idle time past the last result
  localparam int TIMEOUT_NS    = 4_000_000;

  typedef struct packed {
    logic               hit;
    logic [WAY_W-1:0]   way;
    logic [COUNT_W-1:0] hits;
    logic [COUNT_W-1:0] accesses;
  } lookup_res_t;

  // DUT ports; every input has a known value from time zero
  logic                 clk_i       = 1'b0;
  logic                 rst_ni      = 1'b0;
  logic                 cfg_we_i    = 1'b0;
  logic [CFG_W-1:0]     cfg_wdata_i = '0;
  logic                 in_valid_i  = 1'b0;
  logic                 in_ready_o;
  logic [TAG_W-1:0]     tag_i       = '0;
  logic                 out_valid_o;
  logic                 out_ready_i = 1'b0;
  logic                 hit_o;
  logic [WAY_W-1:0]     way_o;
  logic [COUNT_W-1:0]   hit_count_o;
  logic [COUNT_W-1:0]   access_count_o;

  // Cache model state
  logic [TAG_W-1:0]     tag_mem [NUM_WAYS];
  int unsigned          fill_cnt   = 0;
  logic [LFSR_W-1:0]    victim_rng = LFSR_SEED;
  logic [COUNT_W-1:0]   hit_total  = '0;
  logic [COUNT_W-1:0]   acc_total  = '0;
  logic [CFG_W-1:0]     ways_cfg   = WAYS_IN_USE_RST;

  // Bench bookkeeping
  logic [TAG_W-1:0]     pending_tags [$];
  lookup_res_t          expected_lookups [$];
  int unsigned          tags_queued     = 0;
  int unsigned          results_checked = 0;
  int unsigned          mismatches      = 0;
  logic                 in_taken        = 1'b0;
  int unsigned          in_gap_left     = 0;
  int unsigned          out_stall_left  = 0;
  logic                 in_gaps_on      = 1'b0;
  logic                 out_gaps_on     = 1'b0;

  fully_assoc_cache_random_repl dut (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .cfg_we_i       (cfg_we_i),
    .cfg_wdata_i    (cfg_wdata_i),
    .in_valid_i     (in_valid_i),
    .in_ready_o     (in_ready_o),
    .tag_i          (tag_i),
    .out_valid_o    (out_valid_o),
    .out_ready_i    (out_ready_i),
    .hit_o          (hit_o),
    .way_o          (way_o),
    .hit_count_o    (hit_count_o),
    .access_count_o (access_count_o)
  );

  initial begin
    forever #(CLK_HALF_NS) clk_i = ~clk_i;
  end

  // Model of one lookup. Compare against filled slots only; on a miss either
  // append (while below the effective way count) or step the LFSR and
  // overwrite the victim it selects.
  function automatic lookup_res_t predict_lookup(input logic [TAG_W-1:0] tag);
    lookup_res_t  res;
    int unsigned  eff_ways;
    int unsigned  slot;
    logic         found;
    logic [31:0]  scaled;
    eff_ways = (ways_cfg == '0) ? 1 :
               (ways_cfg > NUM_WAYS) ? NUM_WAYS : int'(ways_cfg);
    found = 1'b0;
    slot  = 0;
    for (int i = 0; i < fill_cnt; i++) begin
      if (!found && tag_mem[i] == tag) begin
        found = 1'b1;
        slot  = i;
      end
    end
    if (acc_total != COUNT_MAX) acc_total = acc_total + 1'b1;
    if (found) begin
      if (hit_total != COUNT_MAX) hit_total = hit_total + 1'b1;
    end else if (fill_cnt < eff_ways) begin
      slot          = fill_cnt;
      tag_mem[slot] = tag;
      fill_cnt      = fill_cnt + 1;
    end else begin
      // Galois step first, then scale the new value onto 0..ways-1
      victim_rng = {1'b0, victim_rng[LFSR_W-1:1]} ^ (victim_rng[0] ? LFSR_TAPS : '0);
      scaled     = 32'(victim_rng) * 32'(eff_ways);
      slot       = scaled[31:16];
      if (slot >= eff_ways) slot = eff_ways - 1;
      tag_mem[slot] = tag;
    end
    res.hit      = found;
    res.way      = WAY_W'(slot);
    res.hits     = hit_total;
    res.accesses = acc_total;
    return res;
  endfunction

  // Mostly back-to-back, some short gaps, a few long ones
  function automatic int unsigned pick_gap();
    int unsigned r;
    r = $urandom_range(0, 99);
    if (r < 55) return 0;
    if (r < 90) return $urandom_range(1, 3);
    return $urandom_range(4, 24);
  endfunction

  task automatic check_field(input string name, input logic [31:0] want,
                             input logic [31:0] got);
    if (want !== got) begin
      $display("%0t ns: %s mismatch, expected 0x%0h, actual 0x%0h",
               $time, name, want, got);
      mismatches++;
    end
  endtask

  // Monitor: results are checked and input transactions predicted at the
  // rising edge, when both handshake sides are stable.
  always @(posedge clk_i) begin
    lookup_res_t want;
    if (rst_ni) begin
      if (out_valid_o && out_ready_i) begin
        if (expected_lookups.size() == 0) begin
          $display("%0t ns: unexpected result, actual hit=%0b way=%0d", $time,
                   hit_o, way_o);
          mismatches++;
        end else begin
          want = expected_lookups.pop_front();
          check_field("hit", 32'(want.hit), 32'(hit_o));
          check_field("way", 32'(want.way), 32'(way_o));
          check_field("hit_count", want.hits, hit_count_o);
          check_field("access_count", want.accesses, access_count_o);
          results_checked++;
        end
      end
      if (in_valid_i && in_ready_o) begin
        expected_lookups.insert(expected_lookups.size(), predict_lookup(tag_i));
        in_taken = 1'b1;
      end
    end
  end

  // Driver: inputs change on the falling edge. Valid holds with a stable tag
  // until the monitor has seen the transaction accepted.
  always @(negedge clk_i) begin
    if (rst_ni) begin
      if (!in_valid_i || in_taken) begin
        in_taken = 1'b0;
        if (in_gap_left != 0) begin
          in_valid_i <= 1'b0;
          in_gap_left--;
        end else if (pending_tags.size() != 0) begin
          in_valid_i <= 1'b1;
          tag_i      <= pending_tags.pop_front();
          if (in_gaps_on) in_gap_left = pick_gap();
        end else begin
          in_valid_i <= 1'b0;
        end
      end
      // Result side back-pressure
      if (out_stall_left != 0) begin
        out_ready_i <= 1'b0;
        out_stall_left--;
      end else begin
        out_ready_i <= 1'b1;
        if (out_gaps_on) out_stall_left = pick_gap();
      end
    end
  end

  task automatic queue_tag(input logic [TAG_W-1:0] t);
    pending_tags.insert(pending_tags.size(), t);
    tags_queued++;
  endtask

  // Called on a falling edge. Idle means every queued tag has been handed
  // out and its result checked; both counts are stable at this edge.
  task automatic wait_idle();
    while (pending_tags.size() != 0 || results_checked != tags_queued)
      @(negedge clk_i);
  endtask

  task automatic write_ways(input logic [CFG_W-1:0] v);
    wait_idle();
    cfg_we_i    <= 1'b1;
    cfg_wdata_i <= v;
    ways_cfg     = v;
    @(negedge clk_i);
    cfg_we_i    <= 1'b0;
  endtask

  // Random phase: working set slightly larger than the cache so hits,
  // fills and replacements all occur, plus fresh tags and near-extreme tags.
  task automatic run_random_phase();
    logic [TAG_W-1:0] pool [POOL_SIZE];
    int unsigned      r;
    for (int i = 0; i < POOL_SIZE; i++) pool[i] = $urandom();
    for (int n = 0; n < PHASE_ITEMS; n++) begin
      r = $urandom_range(0, 99);
      if (r < 70)
        queue_tag(pool[$urandom_range(0, POOL_SIZE - 1)]);
      else if (r < 85)
        queue_tag($urandom());
      else
        queue_tag(({TAG_W{1'b1}} & {TAG_W{r[0]}}) ^ (TAG_W'(1) << $urandom_range(0, 31)));
    end
  endtask

  // Stimulus sequence
  initial begin
    logic [CFG_W-1:0] ways_val;
    for (int i = 0; i < NUM_WAYS; i++) tag_mem[i] = '0;
    repeat (4) @(negedge clk_i);
    rst_ni <= 1'b1;
    @(negedge clk_i);

    // Two ways right after reset: fills, hits, then replacement between two
    write_ways(CFG_W'(2));
    queue_tag(32'h0000_0000);
    queue_tag(32'hFFFF_FFFF);
    queue_tag(32'h0000_0000);
    queue_tag(32'hFFFF_FFFF);
    queue_tag(32'h8000_0000);
    queue_tag(32'h0000_0001);
    queue_tag(32'h8000_0000);
    queue_tag(32'h7FFF_FFFF);

    // Way count above the slot count clamps to all slots; fill the rest,
    // then hit and replace across the full set
    in_gaps_on  = 1'b1;
    out_gaps_on = 1'b1;
    write_ways(CFG_W'(31));
    queue_tag(32'hAAAA_AAAA);
    queue_tag(32'h5555_5555);
    for (int i = 0; i < 12; i++) queue_tag(32'h0101_0101 * (i + 2));
    queue_tag(32'hDEAD_BEEF);
    queue_tag(32'hAAAA_AAAA);
    queue_tag(32'h0001_0000);

    // Late writes: filled slots keep matching, victims shrink to the new
    // range; zero acts as one way, seventeen and up clamp to sixteen
    for (int p = 0; p < RAND_PHASES; p++) begin
      case (p)
        0:       ways_val = CFG_W'(1);
        1:       ways_val = CFG_W'(0);
        2:       ways_val = CFG_W'(17);
        3:       ways_val = CFG_W'(16);
        4:       ways_val = CFG_W'(3);
        default: ways_val = CFG_W'($urandom_range(0, 31));
      endcase
      write_ways(ways_val);
      // first random phase runs with no idling on either side
      in_gaps_on  = (p != 0) && ($urandom_range(0, 3) != 0);
      out_gaps_on = (p != 0) && ($urandom_range(0, 3) != 0);
      run_random_phase();
    end

    wait_idle();
    repeat (DRAIN_CYCLES) @(posedge clk_i);
    if (mismatches == 0 && expected_lookups.size() == 0) begin
      $display("tb_fully_assoc_cache_random_repl passed");
    end else begin
      $display("tb_fully_assoc_cache_random_repl failed");
    end
    $finish;
  end

  // Watchdog
  initial begin
    #(TIMEOUT_NS);
    $display("tb_fully_assoc_cache_random_repl failed");
    $finish;
  end

endmodule

/* fully_assoc_cache_random_repl.f */
rtl/farc_pkg.sv
rtl/farc_tag_match.sv
rtl/fully_assoc_cache_random_repl.sv
tb/sv/tb_fully_assoc_cache_random_repl.sv
